FILE: rtl/core/trle_pkg.sv
// Shared types and constants of the TGA run-length pixel encoder.
`default_nettype none

package trle_pkg;

    // Sizes of the write pointer and of the row geometry.
    localparam int OFFSET_BITS   = 24;
    localparam int MAX_ROW_WIDTH = 4096;
    localparam int COL_BITS      = $clog2(MAX_ROW_WIDTH);
    localparam int EW_BITS       = COL_BITS + 1;
    localparam int ROW_CFG_BITS  = 13;

    // Configuration port geometry.
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_GRAY_MODE = 1'b1;
    localparam logic [ROW_CFG_BITS-1:0] ROW_WIDTH_RESET = 13'd256;

    // Packet header codes and limits.
    localparam logic [7:0] RAW_HEADER = 8'd0;
    localparam logic [7:0] RUN_HEADER = 8'd128;
    localparam logic [7:0] RUN_LIMIT  = 8'd254;
    localparam logic [7:0] RAW_LIMIT  = 8'd127;

    // Byte counts of one write.
    localparam logic [1:0] BYTES_ONE   = 2'd1;
    localparam logic [1:0] BYTES_THREE = 2'd3;

    // One item can cause at most this many writes.
    localparam int MAX_WRITES = 4;
    localparam int CNT_BITS   = $clog2(MAX_WRITES + 1);
    localparam int IDX_BITS   = $clog2(MAX_WRITES);

    // Input item.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       end_of_image;
    } in_item_t;

    // Result item: one buffer write.
    typedef struct packed {
        logic [23:0] write_offset;
        logic [23:0] write_value;
        logic [1:0]  write_bytes;
        logic        is_header;
        logic        is_last;
    } out_item_t;

    // Registered pixel with its channel mean.
    typedef struct packed {
        logic [23:0] pixel;
        logic [7:0]  mean;
        logic        last;
    } pixel_word_t;

    // Writes of one item, handed from the encoder to the result buffer.
    typedef struct packed {
        logic                            load;
        logic [CNT_BITS-1:0]             count;
        out_item_t [MAX_WRITES-1:0]      slot;
    } write_batch_t;

endpackage

`default_nettype wire

FILE: rtl/core/trle_apb_regs.sv
// Configuration registers of the encoder behind an APB-style port.
`default_nettype none

module trle_apb_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [trle_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [trle_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [trle_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready,
    output logic [trle_pkg::ROW_CFG_BITS-1:0]    row_width,
    output logic                                 gray_mode
);
    import trle_pkg::*;

    logic [ROW_CFG_BITS-1:0] row_width_reg;
    logic                    gray_mode_reg;
    logic                    wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            gray_mode_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_ROW_WIDTH: row_width_reg <= pwdata[ROW_CFG_BITS-1:0];
                REG_GRAY_MODE: gray_mode_reg <= pwdata[0];
                default:       row_width_reg <= row_width_reg;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        case (paddr[2])
            REG_ROW_WIDTH: prdata = PDATA_BITS'(row_width_reg);
            REG_GRAY_MODE: prdata = PDATA_BITS'(gray_mode_reg);
            default:       prdata = '0;
        endcase
    end

    assign row_width = row_width_reg;
    assign gray_mode = gray_mode_reg;

endmodule

`default_nettype wire

FILE: rtl/core/trle_pixel_in.sv
// Input register of the encoder: latches a pixel and its channel mean.
`default_nettype none

module trle_pixel_in (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  trle_pkg::in_item_t     pixel,
    input  logic                   take,
    output trle_pkg::pixel_word_t  word,
    output logic                   word_valid
);
    import trle_pkg::*;

    logic        valid_reg;
    pixel_word_t word_reg;
    pixel_word_t word_next;
    logic [9:0]  chan_sum;
    logic [20:0] mean_prod;

    // The register frees up when the encoder takes its item.
    assign pixel_stall = valid_reg && !take;

    // Mean of the three channels: multiply by 683/2048, exact for sums below 2048.
    always_comb
    begin
        chan_sum  = 10'(pixel.blue) + 10'(pixel.green) + 10'(pixel.red);
        mean_prod = 21'(chan_sum) * 21'd683;
        word_next.pixel = {pixel.red, pixel.green, pixel.blue};
        word_next.mean  = mean_prod[18:11];
        word_next.last  = pixel.end_of_image;
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!pixel_stall)
        begin
            valid_reg <= pixel_valid;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (!pixel_stall && pixel_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign word       = word_reg;
    assign word_valid = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/trle_encoder.sv
// Packet encoder: holds one pixel back and turns each item into up to four writes.
`default_nettype none

module trle_encoder (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [trle_pkg::ROW_CFG_BITS-1:0]    row_width,
    input  logic                                 gray_mode,
    input  trle_pkg::pixel_word_t                word,
    input  logic                                 word_valid,
    input  logic                                 buf_free,
    output logic                                 take,
    output trle_pkg::write_batch_t               batch
);
    import trle_pkg::*;

    typedef struct packed {
        logic                   run_active;
        logic                   packet_open;
        logic [OFFSET_BITS-1:0] header_offset;
        logic [7:0]             header_value;
        logic [OFFSET_BITS-1:0] write_pointer;
    } pkt_state_t;

    typedef struct packed {
        pkt_state_t st;
        logic [1:0] count;
        out_item_t  w0;
        out_item_t  w1;
    } enc_result_t;

    pkt_state_t         pkt_reg;
    logic [23:0]        held_pixel_reg;
    logic [7:0]         held_mean_reg;
    logic               held_valid_reg;
    logic [COL_BITS-1:0] column_reg;

    logic [EW_BITS-1:0] eff_width;
    logic [EW_BITS-1:0] col_plus;
    logic               same;
    logic [1:0]         nbytes;
    logic [23:0]        held_val;
    logic [23:0]        cur_val;
    enc_result_t        res_a;
    enc_result_t        res_b;
    pkt_state_t         st_a;
    logic [1:0]         cnt_a;
    logic [1:0]         cnt_b;
    logic [CNT_BITS-1:0] total;

    function automatic out_item_t header_write(input logic [OFFSET_BITS-1:0] ptr,
                                               input logic [7:0] hv);
        out_item_t w;
        w.write_offset = 24'(ptr);
        w.write_value  = 24'(hv);
        w.write_bytes  = BYTES_ONE;
        w.is_header    = 1'b1;
        w.is_last      = 1'b0;
        return w;
    endfunction

    function automatic out_item_t data_write(input logic [OFFSET_BITS-1:0] ptr,
                                             input logic [23:0] val,
                                             input logic [1:0] nb);
        out_item_t w;
        w.write_offset = 24'(ptr);
        w.write_value  = val;
        w.write_bytes  = nb;
        w.is_header    = 1'b0;
        w.is_last      = 1'b0;
        return w;
    endfunction

    // Opens a packet: header write, then the first pixel.
    function automatic enc_result_t open_packet(input pkt_state_t s, input logic [7:0] hv,
                                                input logic [23:0] val, input logic [1:0] nb);
        enc_result_t r;
        r.st               = s;
        r.st.header_offset = s.write_pointer;
        r.st.header_value  = hv;
        r.st.packet_open   = 1'b1;
        r.w0               = header_write(s.write_pointer, hv);
        r.w1               = data_write(s.write_pointer + OFFSET_BITS'(1), val, nb);
        r.st.write_pointer = s.write_pointer + OFFSET_BITS'(1) + OFFSET_BITS'(nb);
        r.count            = 2'd2;
        return r;
    endfunction

    // Encodes one pixel, given whether its successor equals it.
    function automatic enc_result_t encode_pixel(input pkt_state_t s, input logic [23:0] val,
                                                 input logic [1:0] nb, input logic eq);
        enc_result_t r;
        logic [7:0]  hv_inc;
        r       = '0;
        r.st    = s;
        hv_inc  = s.header_value + 8'd1;
        if (eq && !(s.run_active && s.header_value == RUN_LIMIT))
        begin
            if (!s.run_active)
            begin
                r = open_packet(s, RUN_HEADER, val, nb);
            end
            else
            begin
                r.st.header_value = hv_inc;
                r.w0              = header_write(s.header_offset, hv_inc);
                r.count           = 2'd1;
            end
            r.st.run_active = 1'b1;
        end
        else
        begin
            if (s.run_active)
            begin
                // A run closes with its final count patch.
                r.st.header_value = hv_inc;
                r.w0              = header_write(s.header_offset, hv_inc);
                r.st.packet_open  = 1'b0;
                r.count           = 2'd1;
            end
            else if (!s.packet_open)
            begin
                r = open_packet(s, RAW_HEADER, val, nb);
            end
            else
            begin
                // Grow a raw packet: data, then patch; it closes when full.
                r.w0               = data_write(s.write_pointer, val, nb);
                r.st.write_pointer = s.write_pointer + OFFSET_BITS'(nb);
                r.st.header_value  = hv_inc;
                r.w1               = header_write(s.header_offset, hv_inc);
                r.count            = 2'd2;
                if (hv_inc == RAW_LIMIT)
                begin
                    r.st.packet_open = 1'b0;
                end
            end
            r.st.run_active = 1'b0;
        end
        return r;
    endfunction

    assign take = word_valid && buf_free;

    // Effective row width and the run-at-row-end test.
    always_comb
    begin
        if (row_width == '0)
        begin
            eff_width = EW_BITS'(1);
        end
        else if (32'(row_width) > MAX_ROW_WIDTH)
        begin
            eff_width = EW_BITS'(MAX_ROW_WIDTH);
        end
        else
        begin
            eff_width = EW_BITS'(row_width);
        end
        col_plus = EW_BITS'(column_reg) + EW_BITS'(1);
    end

    // Two encode passes: the held pixel, then the last pixel at image end.
    always_comb
    begin
        nbytes   = gray_mode ? BYTES_ONE : BYTES_THREE;
        held_val = gray_mode ? 24'(held_mean_reg) : held_pixel_reg;
        cur_val  = gray_mode ? 24'(word.mean) : word.pixel;
        same     = held_valid_reg && (col_plus < eff_width) &&
                   (gray_mode ? (held_mean_reg == word.mean) : (held_pixel_reg == word.pixel));
        res_a    = encode_pixel(pkt_reg, held_val, nbytes, same);
        st_a     = held_valid_reg ? res_a.st : pkt_reg;
        cnt_a    = held_valid_reg ? res_a.count : 2'd0;
        res_b    = encode_pixel(st_a, cur_val, nbytes, 1'b0);
        cnt_b    = word.last ? res_b.count : 2'd0;
        total    = CNT_BITS'(cnt_a) + CNT_BITS'(cnt_b);
    end

    // Pack the writes in order into the batch.
    always_comb
    begin
        batch.load  = take;
        batch.count = total;
        batch.slot  = '0;
        case (cnt_a)
            2'd0:
            begin
                batch.slot[0] = res_b.w0;
                batch.slot[1] = res_b.w1;
            end
            2'd1:
            begin
                batch.slot[0] = res_a.w0;
                batch.slot[1] = res_b.w0;
                batch.slot[2] = res_b.w1;
            end
            default:
            begin
                batch.slot[0] = res_a.w0;
                batch.slot[1] = res_a.w1;
                batch.slot[2] = res_b.w0;
                batch.slot[3] = res_b.w1;
            end
        endcase
        for (int j = 0; j < MAX_WRITES; j++)
        begin
            if (word.last && (CNT_BITS'(j) == total - CNT_BITS'(1)))
            begin
                batch.slot[j].is_last = 1'b1;
            end
        end
    end

    // Stream state; an image end returns everything to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_reg        <= '0;
            held_pixel_reg <= '0;
            held_mean_reg  <= '0;
            held_valid_reg <= 1'b0;
            column_reg     <= '0;
        end
        else if (take)
        begin
            if (word.last)
            begin
                pkt_reg        <= '0;
                held_pixel_reg <= '0;
                held_mean_reg  <= '0;
                held_valid_reg <= 1'b0;
                column_reg     <= '0;
            end
            else
            begin
                pkt_reg        <= st_a;
                held_pixel_reg <= word.pixel;
                held_mean_reg  <= word.mean;
                held_valid_reg <= 1'b1;
                if (held_valid_reg)
                begin
                    column_reg <= (col_plus >= eff_width) ? '0 : col_plus[COL_BITS-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/trle_result_buf.sv
// Result buffer: holds one item's writes, handing out one per unstalled cycle.
`default_nettype none

module trle_result_buf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  trle_pkg::write_batch_t  batch,
    output logic                    buf_free,
    output logic                    write_valid,
    input  logic                    write_stall,
    output trle_pkg::out_item_t     write_item
);
    import trle_pkg::*;

    out_item_t [MAX_WRITES-1:0] slot_reg;
    logic [CNT_BITS-1:0]        count_reg;
    logic [IDX_BITS-1:0]        idx_reg;
    logic                       fire;

    assign write_valid = (count_reg != '0);
    assign fire        = write_valid && !write_stall;
    assign buf_free    = (count_reg == '0) || ((count_reg == CNT_BITS'(1)) && fire);
    assign write_item  = slot_reg[idx_reg];

    // Remaining count and read index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (batch.load)
        begin
            count_reg <= batch.count;
            idx_reg   <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_reg - CNT_BITS'(1);
            idx_reg   <= idx_reg + IDX_BITS'(1);
        end
    end

    // Write slots.
    always_ff @(posedge clk)
    begin
        if (batch.load)
        begin
            slot_reg <= batch.slot;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tga_rle_pixel_encoder_core.sv
// Top level of the TGA run-length pixel encoder.
// Pixels enter on the pixel channel (valid/stall); each accepted item is one pixel,
// with end_of_image set on the last pixel of an image. Buffer writes leave on the
// write channel, one write per item, in the order the packet layout requires.
// A pixel is held back until its successor arrives, so the first pixel of an image
// causes no write; an item causes between zero and four writes.
// An accepted item passes the input register, then the encoder loads its writes
// into the result buffer, which presents them on the write channel.
// Throughput: one pixel per cycle while nothing stalls and each item causes at most
// one write; the result buffer drains one write per unstalled cycle and reloads in
// the cycle its last write is taken, so items with more writes hold up pixels.
// When the receiver stalls, the presented write holds and the buffer fills; the
// pixel channel stalls once the input register holds an item that cannot load.
// Reset clears all stream state and sets row_width to 256 and gray_mode to 0.
// After an image end the stream state returns to reset; the next image starts at
// offset 0. Configuration is written through the APB-style port; the user must
// write it only while idle, as the block itself does not enforce this.
`default_nettype none

module tga_rle_pixel_encoder_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  trle_pkg::in_item_t                pixel,
    output logic                              write_valid,
    input  logic                              write_stall,
    output trle_pkg::out_item_t               write_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trle_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [trle_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [trle_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready
);
    import trle_pkg::*;

    logic [ROW_CFG_BITS-1:0] row_width;
    logic                    gray_mode;
    pixel_word_t             word;
    logic                    word_valid;
    logic                    take;
    logic                    buf_free;
    write_batch_t            batch;

    // Configuration registers.
    trle_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .row_width (row_width),
        .gray_mode (gray_mode)
    );

    // Input register.
    trle_pixel_in u_pixel_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .take        (take),
        .word        (word),
        .word_valid  (word_valid)
    );

    // Packet encoder.
    trle_encoder u_encoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_width  (row_width),
        .gray_mode  (gray_mode),
        .word       (word),
        .word_valid (word_valid),
        .buf_free   (buf_free),
        .take       (take),
        .batch      (batch)
    );

    // Result buffer.
    trle_result_buf u_result_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .batch       (batch),
        .buf_free    (buf_free),
        .write_valid (write_valid),
        .write_stall (write_stall),
        .write_item  (write_item)
    );

endmodule

`default_nettype wire

FILE: rtl/core/trle_checker.sv
// Port-level checks on the encoder's write channel, bound to the top level.
`default_nettype none

module trle_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 write_valid,
    input  logic                 write_stall,
    input  trle_pkg::out_item_t  write_item
);
    import trle_pkg::*;

    logic fire;
    assign fire = write_valid && !write_stall;

    // A stalled write stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && write_stall |=> write_valid)
        else $error("write_valid dropped while stalled");

    // A stalled write keeps its payload.
    a_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
        write_valid && write_stall |=> $stable(write_item))
        else $error("write_item changed while stalled");

    // An opening header is followed at once by the packet's first pixel, one byte on.
    a_open_then_data: assert property (@(posedge clk) disable iff (!rst_n)
        fire && write_item.is_header &&
        (write_item.write_value == 24'(RUN_HEADER) || write_item.write_value == 24'(RAW_HEADER))
        |=> write_valid && !write_item.is_header &&
            write_item.write_offset == $past(write_item.write_offset) + 24'd1)
        else $error("opening header not followed by its pixel data");

    // After the last write of an image, the next image starts with a header at offset 0.
    a_restart_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fire && write_item.is_last
        |=> !write_valid || (write_item.is_header && write_item.write_offset == 24'd0))
        else $error("new image does not start at offset zero");

endmodule

bind tga_rle_pixel_encoder_core trle_checker u_trle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .write_valid (write_valid),
    .write_stall (write_stall),
    .write_item  (write_item)
);

`default_nettype wire
